// ===== rtl/rtc_pkg.sv =====
// ----------------------------------------------------------------------------
// rtc_pkg: shared types, constants and calendar functions
// Transaction payloads, counter cell control, and the leap year, month
// length, and weekday arithmetic used by the clock and its weekday pipeline.
// ----------------------------------------------------------------------------
package rtc_pkg;

    // widths
    localparam int CELL_W  = 14;
    localparam int YEAR_W  = 14;
    localparam int SUM_W   = 16;

    // cell positions along the carry chain
    localparam int CELL_SEC   = 0;
    localparam int CELL_MIN   = 1;
    localparam int CELL_HOUR  = 2;
    localparam int CELL_DAY   = 3;
    localparam int CELL_MONTH = 4;
    localparam int CELL_YEAR  = 5;
    localparam int NUM_CELLS  = 6;

    // transaction kinds
    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_SET  = 1'b1;

    // limits
    localparam logic [5:0]        SEC_MAX   = 6'd59;
    localparam logic [5:0]        MIN_MAX   = 6'd59;
    localparam logic [4:0]        HOUR_MAX  = 5'd23;
    localparam logic [3:0]        MONTH_MAX = 4'd12;
    localparam logic [YEAR_W-1:0] MAX_YEAR  = 14'd9999;

    // values after reset: 00:00:00 on 1 January 2000
    localparam logic [CELL_W-1:0] SEC_INIT   = 14'd0;
    localparam logic [CELL_W-1:0] MIN_INIT   = 14'd0;
    localparam logic [CELL_W-1:0] HOUR_INIT  = 14'd0;
    localparam logic [CELL_W-1:0] DAY_INIT   = 14'd1;
    localparam logic [CELL_W-1:0] MONTH_INIT = 14'd1;
    localparam logic [YEAR_W-1:0] YEAR_INIT  = 14'd2000;

    typedef struct packed {
        logic        kind;
        logic [5:0]  set_second;
        logic [5:0]  set_minute;
        logic [4:0]  set_hour;
        logic [4:0]  set_day;
        logic [3:0]  set_month;
        logic [13:0] set_year;
    } rtc_in_t;

    typedef struct packed {
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic [2:0]  weekday;
    } rtc_out_t;

    // date and time leaving the counter chain
    typedef struct packed {
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic        leap;
    } rtc_snap_t;

    // control of one counter cell
    typedef struct packed {
        logic              step;
        logic              load;
        logic [CELL_W-1:0] load_value;
        logic [CELL_W-1:0] low;
        logic [CELL_W-1:0] high;
        logic [CELL_W-1:0] init;
    } rtc_cell_ctl_t;

    // gregorian leap rule; divisibility by 25 via reciprocal multiply
    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        logic [26:0] prod;
        logic [9:0]  q;
        logic [13:0] back;
        prod = {13'd0, y} * 27'd5243;
        q    = prod[26:17];
        back = ({4'd0, q} << 4) + ({4'd0, q} << 3) + {4'd0, q};
        return (y[1:0] == 2'd0) && ((back != y) || (y[3:0] == 4'd0));
    endfunction

    // days in a month
    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        unique case (m) inside
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            4'd2:                    len = leap ? 5'd29 : 5'd28;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

    // days before the month, mod 7
    function automatic logic [2:0] cum_mod7(input logic [3:0] m, input logic leap);
        logic [2:0] base;
        logic [2:0] res;
        unique case (m)
            4'd1:    base = 3'd0;
            4'd2:    base = 3'd3;
            4'd3:    base = 3'd3;
            4'd4:    base = 3'd6;
            4'd5:    base = 3'd1;
            4'd6:    base = 3'd4;
            4'd7:    base = 3'd6;
            4'd8:    base = 3'd2;
            4'd9:    base = 3'd5;
            4'd10:   base = 3'd0;
            4'd11:   base = 3'd3;
            4'd12:   base = 3'd5;
            default: base = 3'd0;
        endcase
        if (leap && (m > 4'd2))
        begin
            res = (base == 3'd6) ? 3'd0 : base + 3'd1;
        end
        else
        begin
            res = base;
        end
        return res;
    endfunction

    // floor(p / 100) for p below 2^14
    function automatic logic [7:0] div100(input logic [YEAR_W-1:0] p);
        logic [27:0] prod;
        prod = {14'd0, p} * 28'd10486;
        return prod[27:20];
    endfunction

    // residue mod 7 by folding octal digits (8 is 1 mod 7)
    function automatic logic [2:0] mod7(input logic [SUM_W-1:0] s);
        logic [5:0] a;
        logic [3:0] t;
        logic [3:0] u;
        a = {3'd0, s[2:0]} + {3'd0, s[5:3]} + {3'd0, s[8:6]} + {3'd0, s[11:9]}
          + {3'd0, s[14:12]} + {5'd0, s[15]};
        t = {1'b0, a[2:0]} + {1'b0, a[5:3]};
        u = {1'b0, t[2:0]} + {3'd0, t[3]};
        return (u == 4'd7) ? 3'd0 : u[2:0];
    endfunction

endpackage

// ===== rtl/rtc_if.sv =====
// ----------------------------------------------------------------------------
// rtc_if: transaction channels of the clock
// Valid/ready channels carrying command and result payloads.
// ----------------------------------------------------------------------------

// command channel
interface rtc_cmd_if;
    logic             valid;
    logic             ready;
    rtc_pkg::rtc_in_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// result channel
interface rtc_rsp_if;
    logic              valid;
    logic              ready;
    rtc_pkg::rtc_out_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/rtc_cell.sv =====
// ----------------------------------------------------------------------------
// rtc_cell: one counter cell of the time and date chain
// Holds one field, loads it, or advances it on a carry from its lower
// neighbor, wrapping from its upper bound to its lower bound.
// ----------------------------------------------------------------------------
module rtc_cell (
    input  logic                               clk,
    input  logic                               rst_n,
    input  rtc_pkg::rtc_cell_ctl_t             ctl,
    input  logic                               carry_in,
    output logic                               carry_out,
    output logic [rtc_pkg::CELL_W-1:0]         value
);

    logic [rtc_pkg::CELL_W-1:0] value_reg;
    logic [rtc_pkg::CELL_W-1:0] value_next;
    logic                       at_top;

    // wrap detect and carry to the upper neighbor
    assign at_top    = (value_reg >= ctl.high);
    assign carry_out = carry_in & at_top;
    assign value     = value_reg;

    // load, advance or hold
    always_comb
    begin
        value_next = value_reg;
        if (ctl.load)
        begin
            value_next = ctl.load_value;
        end
        else if (carry_in)
        begin
            value_next = at_top ? ctl.low : rtc_pkg::CELL_W'(value_reg + 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= ctl.init;
        end
        else if (ctl.step)
        begin
            value_reg <= value_next;
        end
    end

endmodule

// ===== rtl/rtc_weekday.sv =====
// ----------------------------------------------------------------------------
// rtc_weekday: weekday pipeline and result register
// Three stages: year quotient, day count sum, residue mod 7 into the
// output register, each with its own valid bit and stall control.
// ----------------------------------------------------------------------------
module rtc_weekday (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                snap_valid,
    output logic                snap_ready,
    input  rtc_pkg::rtc_snap_t  snap,
    rtc_rsp_if.source           rsp
);

    logic                             s2_valid_reg;
    rtc_pkg::rtc_snap_t               s2_snap_reg;
    logic [rtc_pkg::YEAR_W-1:0]       s2_p_reg;
    logic [7:0]                       s2_q100_reg;

    logic                             s3_valid_reg;
    rtc_pkg::rtc_snap_t               s3_snap_reg;
    logic [rtc_pkg::SUM_W-1:0]        s3_sum_reg;

    logic                             out_valid_reg;
    rtc_pkg::rtc_out_t                out_reg;

    logic                             en2;
    logic                             en3;
    logic                             en4;
    logic [rtc_pkg::YEAR_W-1:0]       p_next;
    logic [rtc_pkg::SUM_W-1:0]        sum_next;
    rtc_pkg::rtc_out_t                out_next;

    // stage enables: a stage loads when empty or when its contents move on
    assign en4        = !out_valid_reg || rsp.ready;
    assign en3        = !s3_valid_reg || en4;
    assign en2        = !s2_valid_reg || en3;
    assign snap_ready = en2;

    // years before the current one
    assign p_next = snap.year - 1'b1;

    // day count: p + p/4 - p/100 + p/400 + days before month + day
    assign sum_next = {2'd0, s2_p_reg}
                    + {4'd0, s2_p_reg[rtc_pkg::YEAR_W-1:2]}
                    - {8'd0, s2_q100_reg}
                    + {10'd0, s2_q100_reg[7:2]}
                    + {13'd0, rtc_pkg::cum_mod7(s2_snap_reg.month, s2_snap_reg.leap)}
                    + {11'd0, s2_snap_reg.day};

    // result fields
    always_comb
    begin
        out_next.second  = s3_snap_reg.second;
        out_next.minute  = s3_snap_reg.minute;
        out_next.hour    = s3_snap_reg.hour;
        out_next.day     = s3_snap_reg.day;
        out_next.month   = s3_snap_reg.month;
        out_next.year    = s3_snap_reg.year;
        out_next.weekday = rtc_pkg::mod7(s3_sum_reg);
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en2)
            begin
                s2_valid_reg <= snap_valid;
            end
            if (en3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (en4)
            begin
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (en2 && snap_valid)
        begin
            s2_snap_reg <= snap;
            s2_p_reg    <= p_next;
            s2_q100_reg <= rtc_pkg::div100(p_next);
        end
        if (en3 && s2_valid_reg)
        begin
            s3_snap_reg <= s2_snap_reg;
            s3_sum_reg  <= sum_next;
        end
        if (en4 && s3_valid_reg)
        begin
            out_reg <= out_next;
        end
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_reg;

endmodule

// ===== rtl/calendar_clock_with_weekday.sv =====
// ----------------------------------------------------------------------------
// calendar_clock_with_weekday: real-time clock and gregorian calendar
// Tick and set transactions drive a chain of counter cells; every
// transaction returns the date, time and weekday after it.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock cycle unless the weekday pipeline
// stalls it, and returns one result for each, in order. An accepted
// transaction is first registered in the counter cells, and its result waits
// in the output register until the result side takes it. The carry ripples
// through six counter cells (seconds, minutes, hours, day, month, year) in the
// accepting cycle; the weekday is then worked out in a three-stage pipeline
// (year quotient, day count, mod 7) ending in the output register. A set
// transaction saturates out-of-range fields and clamps the day to the month's
// length. The year wraps from 9999 to 1. After reset the clock reads 00:00:00
// on Saturday, 1 January 2000.
module calendar_clock_with_weekday (
    input  logic        clk,
    input  logic        rst_n,
    rtc_cmd_if.sink     cmd,
    rtc_rsp_if.source   rsp
);

    rtc_pkg::rtc_cell_ctl_t           cell_ctl [rtc_pkg::NUM_CELLS];
    logic [rtc_pkg::CELL_W-1:0]       cell_val [rtc_pkg::NUM_CELLS];
    logic [rtc_pkg::NUM_CELLS:0]      carry;

    logic                             accept;
    logic                             kind_set;
    logic                             s1_valid_reg;
    logic                             leap_reg;
    logic                             leap_next;
    logic                             snap_ready;
    rtc_pkg::rtc_snap_t               snap;

    logic [5:0]                       set_sec_c;
    logic [5:0]                       set_min_c;
    logic [4:0]                       set_hour_c;
    logic [3:0]                       set_month_c;
    logic [rtc_pkg::YEAR_W-1:0]       set_year_c;
    logic [4:0]                       set_day_c;
    logic [4:0]                       set_len;
    logic                             leap_set;
    logic [rtc_pkg::YEAR_W-1:0]       year_inc;

    assign accept   = cmd.valid && cmd.ready;
    assign kind_set = (cmd.payload.kind == rtc_pkg::KIND_SET);
    assign cmd.ready = !s1_valid_reg || snap_ready;

    // saturate the loaded fields
    always_comb
    begin
        set_sec_c   = (cmd.payload.set_second > rtc_pkg::SEC_MAX) ? rtc_pkg::SEC_MAX
                                                                  : cmd.payload.set_second;
        set_min_c   = (cmd.payload.set_minute > rtc_pkg::MIN_MAX) ? rtc_pkg::MIN_MAX
                                                                  : cmd.payload.set_minute;
        set_hour_c  = (cmd.payload.set_hour > rtc_pkg::HOUR_MAX) ? rtc_pkg::HOUR_MAX
                                                                 : cmd.payload.set_hour;
        if (cmd.payload.set_month == 4'd0)
        begin
            set_month_c = 4'd1;
        end
        else if (cmd.payload.set_month > rtc_pkg::MONTH_MAX)
        begin
            set_month_c = rtc_pkg::MONTH_MAX;
        end
        else
        begin
            set_month_c = cmd.payload.set_month;
        end
        if (cmd.payload.set_year == '0)
        begin
            set_year_c = rtc_pkg::YEAR_W'(1);
        end
        else if (cmd.payload.set_year > rtc_pkg::MAX_YEAR)
        begin
            set_year_c = rtc_pkg::MAX_YEAR;
        end
        else
        begin
            set_year_c = cmd.payload.set_year;
        end
    end

    // clamp the loaded day to the loaded month
    assign leap_set = rtc_pkg::is_leap(set_year_c);
    assign set_len  = rtc_pkg::month_len(set_month_c, leap_set);
    always_comb
    begin
        if (cmd.payload.set_day == 5'd0)
        begin
            set_day_c = 5'd1;
        end
        else if (cmd.payload.set_day > set_len)
        begin
            set_day_c = set_len;
        end
        else
        begin
            set_day_c = cmd.payload.set_day;
        end
    end

    // cell control along the chain
    always_comb
    begin
        for (int i = 0; i < rtc_pkg::NUM_CELLS; i++)
        begin
            cell_ctl[i].step = accept;
            cell_ctl[i].load = kind_set;
        end
        cell_ctl[rtc_pkg::CELL_SEC].load_value   = {8'd0, set_sec_c};
        cell_ctl[rtc_pkg::CELL_SEC].low          = '0;
        cell_ctl[rtc_pkg::CELL_SEC].high         = {8'd0, rtc_pkg::SEC_MAX};
        cell_ctl[rtc_pkg::CELL_SEC].init         = rtc_pkg::SEC_INIT;

        cell_ctl[rtc_pkg::CELL_MIN].load_value   = {8'd0, set_min_c};
        cell_ctl[rtc_pkg::CELL_MIN].low          = '0;
        cell_ctl[rtc_pkg::CELL_MIN].high         = {8'd0, rtc_pkg::MIN_MAX};
        cell_ctl[rtc_pkg::CELL_MIN].init         = rtc_pkg::MIN_INIT;

        cell_ctl[rtc_pkg::CELL_HOUR].load_value  = {9'd0, set_hour_c};
        cell_ctl[rtc_pkg::CELL_HOUR].low         = '0;
        cell_ctl[rtc_pkg::CELL_HOUR].high        = {9'd0, rtc_pkg::HOUR_MAX};
        cell_ctl[rtc_pkg::CELL_HOUR].init        = rtc_pkg::HOUR_INIT;

        cell_ctl[rtc_pkg::CELL_DAY].load_value   = {9'd0, set_day_c};
        cell_ctl[rtc_pkg::CELL_DAY].low          = rtc_pkg::CELL_W'(1);
        cell_ctl[rtc_pkg::CELL_DAY].high         =
            {9'd0, rtc_pkg::month_len(cell_val[rtc_pkg::CELL_MONTH][3:0], leap_reg)};
        cell_ctl[rtc_pkg::CELL_DAY].init         = rtc_pkg::DAY_INIT;

        cell_ctl[rtc_pkg::CELL_MONTH].load_value = {10'd0, set_month_c};
        cell_ctl[rtc_pkg::CELL_MONTH].low        = rtc_pkg::CELL_W'(1);
        cell_ctl[rtc_pkg::CELL_MONTH].high       = {10'd0, rtc_pkg::MONTH_MAX};
        cell_ctl[rtc_pkg::CELL_MONTH].init       = rtc_pkg::MONTH_INIT;

        cell_ctl[rtc_pkg::CELL_YEAR].load_value  = set_year_c;
        cell_ctl[rtc_pkg::CELL_YEAR].low         = rtc_pkg::CELL_W'(1);
        cell_ctl[rtc_pkg::CELL_YEAR].high        = rtc_pkg::MAX_YEAR;
        cell_ctl[rtc_pkg::CELL_YEAR].init        = rtc_pkg::YEAR_INIT;
    end

    // a tick enters the chain at the seconds cell
    assign carry[0] = !kind_set;

    // counter cell chain
    for (genvar g = 0; g < rtc_pkg::NUM_CELLS; g++)
    begin : g_cell
        rtc_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (cell_ctl[g]),
            .carry_in  (carry[g]),
            .carry_out (carry[g+1]),
            .value     (cell_val[g])
        );
    end

    // leap flag follows the year cell
    assign year_inc = carry[rtc_pkg::NUM_CELLS] ? rtc_pkg::YEAR_W'(1)
                    : rtc_pkg::YEAR_W'(cell_val[rtc_pkg::CELL_YEAR] + 1'b1);
    always_comb
    begin
        if (kind_set)
        begin
            leap_next = leap_set;
        end
        else if (carry[rtc_pkg::CELL_YEAR])
        begin
            leap_next = rtc_pkg::is_leap(year_inc);
        end
        else
        begin
            leap_next = leap_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            leap_reg     <= rtc_pkg::is_leap(rtc_pkg::YEAR_INIT);
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                leap_reg     <= leap_next;
                s1_valid_reg <= 1'b1;
            end
            else if (snap_ready)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    // current state handed to the weekday pipeline
    always_comb
    begin
        snap.second = cell_val[rtc_pkg::CELL_SEC][5:0];
        snap.minute = cell_val[rtc_pkg::CELL_MIN][5:0];
        snap.hour   = cell_val[rtc_pkg::CELL_HOUR][4:0];
        snap.day    = cell_val[rtc_pkg::CELL_DAY][4:0];
        snap.month  = cell_val[rtc_pkg::CELL_MONTH][3:0];
        snap.year   = cell_val[rtc_pkg::CELL_YEAR];
        snap.leap   = leap_reg;
    end

    rtc_weekday u_weekday (
        .clk        (clk),
        .rst_n      (rst_n),
        .snap_valid (s1_valid_reg),
        .snap_ready (snap_ready),
        .snap       (snap),
        .rsp        (rsp)
    );

    // leap flag always matches the stored year
    a_leap_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        leap_reg == rtc_pkg::is_leap(cell_val[rtc_pkg::CELL_YEAR]))
        else $error("leap flag out of step with year");

    // day never beyond the month's length
    a_day_in_month: assert property (@(posedge clk) disable iff (!rst_n)
        (cell_val[rtc_pkg::CELL_DAY][4:0] <=
         rtc_pkg::month_len(cell_val[rtc_pkg::CELL_MONTH][3:0], leap_reg)) &&
        (cell_val[rtc_pkg::CELL_DAY] != '0))
        else $error("day outside month");

    // a tick advances seconds by one or wraps them
    a_tick_second: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !kind_set) |=>
        (cell_val[rtc_pkg::CELL_SEC] ==
         rtc_pkg::CELL_W'($past(cell_val[rtc_pkg::CELL_SEC]) + 1'b1)) ||
        (cell_val[rtc_pkg::CELL_SEC] == '0))
        else $error("tick did not advance seconds");

endmodule
